FILE: design/shhm_pkg.sv
// Shared types and constants for the subsystem heartbeat health monitor.
package shhm_pkg;

    localparam int STATUS_W = 3;
    localparam int CODE_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_HEARTBEAT = 3'd1,
        OP_REPORT    = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_START     = 3'd4,
        OP_STOP      = 3'd5,
        OP_TEST      = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_WARNING = 3'd2;
    localparam logic [2:0] ST_ERROR   = 3'd3;
    localparam logic [2:0] ST_OFFLINE = 3'd4;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_SLOW = 2'd2;
    localparam logic [1:0] MODE_FAST = 2'd3;

    localparam logic [1:0] REG_CHECK   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_BLINK   = 2'd2;
    localparam logic [1:0] REG_TEST    = 2'd3;

    // one subsystem record as held in memory
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   fault;
        logic [COUNT_W-1:0]  tally;
        logic [TIME_W-1:0]   beat;
    } sys_rec_t;

    localparam int REC_W = STATUS_W + CODE_W + COUNT_W + TIME_W;

    function automatic logic [1:0] mode_for_status(input logic [2:0] st);
        logic [1:0] m;
        unique case (st)
            ST_OK:      m = MODE_ON;
            ST_WARNING: m = MODE_SLOW;
            ST_ERROR:   m = MODE_FAST;
            ST_OFFLINE: m = MODE_OFF;
            default:    m = MODE_SLOW;
        endcase
        return m;
    endfunction

endpackage

FILE: design/shhm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module shhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/subsystem_heartbeat_health_monitor_top.sv
// Top level of the subsystem heartbeat health monitor.
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid / in_stall    | operation, sys_sel, fault_val
//  out     | source    | out_valid / out_stall  | result_code .. test_step
//  cfg     | sink      | cfg_we                 | cfg_index, cfg_data
// Subsystem records live in one RAM; a clearing pass that zeroes every record
// runs after reset, taking no word. A command runs through accept, read,
// modify/write and report; a tick walks all SYSTEMS records through the RAM
// port. One word is worked on at a time; the next word is taken only once
// no result waits stalled in the output register.
module subsystem_heartbeat_health_monitor_top #(
    parameter int SYSTEMS       = 8,
    parameter int TEST_PHASE_MS = 1000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [3:0]  sys_sel,
    input  logic [15:0] fault_val,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_code,
    output logic [2:0]  system_status,
    output logic [15:0] system_fault_code,
    output logic [31:0] system_fault_count,
    output logic        all_ok,
    output logic [31:0] total_fault_count,
    output logic [31:0] uptime_ms,
    output logic        status_lamp,
    output logic        fault_lamp,
    output logic [7:0]  system_lamps,
    output logic        test_running,
    output logic [3:0]  test_step,
    input  logic        cfg_we,
    input  logic [shhm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shhm_pkg::CFG_W-1:0]     cfg_data
);
    import shhm_pkg::*;

    localparam int AW    = (SYSTEMS > 1) ? $clog2(SYSTEMS) : 1;
    localparam int LAMPS = SYSTEMS + 2;
    localparam int SHOWN = (SYSTEMS < 8) ? SYSTEMS : 8;
    localparam logic [AW:0] LAST = (AW+1)'(SYSTEMS - 1);
    localparam logic [4:0] PHASE_END = 5'(SYSTEMS + 3);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_MOD, S_TICK_RD, S_TICK_MOD, S_LAMPS, S_TEST, S_HOLD
    } state_t;

    state_t state_reg;
    logic [15:0] chk_reg, tmo_reg, blink_reg;
    logic        tos_reg;
    logic [2:0]  op_reg;
    logic [3:0]  id_reg;
    logic [15:0] code_reg;
    logic [AW:0] idx_reg;
    logic [31:0] time_reg, last_chk_reg, last_test_reg, sum_reg;
    logic        healthy_reg, ok_acc_reg, do_check_reg;
    logic        test_act_reg;
    logic [4:0]  phase_reg;
    logic [1:0]  mode_reg [LAMPS];
    logic [31:0] tog_reg [LAMPS];
    logic        lvl_reg [LAMPS];
    logic [2:0]  sys_st_reg [SYSTEMS];

    logic        we;
    logic [AW-1:0] waddr, raddr;
    sys_rec_t    wrec, rrec;
    logic        valid_id;

    shhm_ram #(.WIDTH(REC_W), .DEPTH(SYSTEMS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
        .raddr(raddr), .rdata(rrec)
    );

    assign valid_id = ({1'b0, id_reg} < 5'(SYSTEMS));
    assign in_stall = !(state_reg == S_IDLE && !(out_valid && out_stall));
    assign raddr    = (state_reg == S_IDLE) ? AW'(sys_sel) :
                      (state_reg == S_RD)   ? id_reg[AW-1:0] : idx_reg[AW-1:0];

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wrec  = rrec;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wrec = '0;
            end
            S_MOD:
            begin
                waddr = id_reg[AW-1:0];
                if (valid_id)
                begin
                    unique case (op_reg)
                        OP_HEARTBEAT:
                        begin
                            we = 1'b1;
                            wrec.beat = time_reg;
                            if (rrec.status == ST_OFFLINE)
                            begin
                                wrec.status = ST_OK;
                            end
                        end
                        OP_REPORT:
                        begin
                            we = 1'b1;
                            wrec.status = ST_ERROR;
                            wrec.fault  = code_reg;
                            wrec.beat   = time_reg;
                            wrec.tally  = rrec.tally + 32'd1;
                        end
                        OP_CLEAR:
                        begin
                            we = 1'b1;
                            wrec.status = ST_OK;
                            wrec.fault  = '0;
                            wrec.beat   = time_reg;
                        end
                        default: we = 1'b0;
                    endcase
                end
            end
            S_TICK_MOD:
            begin
                if (do_check_reg && ((time_reg - rrec.beat) > {16'd0, tmo_reg}))
                begin
                    we = 1'b1;
                    wrec.status = ST_OFFLINE;
                    wrec.fault  = '0;
                    wrec.beat   = time_reg;
                end
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            chk_reg       <= 16'd1000;
            tmo_reg       <= 16'd2000;
            blink_reg     <= 16'd500;
            tos_reg       <= 1'b1;
            op_reg        <= '0;
            id_reg        <= '0;
            code_reg      <= '0;
            idx_reg       <= '0;
            time_reg      <= '0;
            last_chk_reg  <= '0;
            last_test_reg <= '0;
            sum_reg       <= '0;
            healthy_reg   <= 1'b0;
            ok_acc_reg    <= 1'b0;
            do_check_reg  <= 1'b0;
            test_act_reg  <= 1'b0;
            phase_reg     <= '0;
            out_valid     <= 1'b0;
            for (int k = 0; k < LAMPS; k++)
            begin
                mode_reg[k] <= MODE_OFF;
                tog_reg[k]  <= '0;
                lvl_reg[k]  <= 1'b0;
            end
            for (int k = 0; k < SYSTEMS; k++)
            begin
                sys_st_reg[k] <= ST_UNKNOWN;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CHECK:   chk_reg   <= cfg_data;
                    REG_TIMEOUT: tmo_reg   <= cfg_data;
                    REG_BLINK:   blink_reg <= cfg_data;
                    REG_TEST:    tos_reg   <= cfg_data[0];
                endcase
            end
            if (out_valid && !out_stall && state_reg != S_HOLD)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (!in_stall && in_valid)
                    begin
                        op_reg   <= operation;
                        id_reg   <= sys_sel;
                        code_reg <= fault_val;
                        idx_reg  <= '0;
                        if (op_t'(operation) == OP_TICK)
                        begin
                            time_reg     <= time_reg + 32'd1;
                            do_check_reg <= ((time_reg + 32'd1 - last_chk_reg)
                                             >= {16'd0, chk_reg});
                            ok_acc_reg   <= 1'b1;
                            state_reg    <= S_TICK_RD;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: state_reg <= S_MOD;
                S_MOD:
                begin
                    unique case (op_reg)
                        OP_START:
                        begin
                            if (tos_reg)
                            begin
                                test_act_reg <= 1'b1;
                                phase_reg    <= '0;
                            end
                        end
                        OP_STOP: test_act_reg <= 1'b0;
                        OP_TEST:
                        begin
                            test_act_reg <= 1'b1;
                            phase_reg    <= '0;
                        end
                        default: ;
                    endcase
                    if (valid_id && we)
                    begin
                        sys_st_reg[id_reg[AW-1:0]] <= wrec.status;
                        if (op_reg == OP_REPORT)
                        begin
                            sum_reg <= sum_reg + 32'd1;
                        end
                    end
                    state_reg <= S_HOLD;
                end
                S_TICK_RD: state_reg <= S_TICK_MOD;
                S_TICK_MOD:
                begin
                    sys_st_reg[idx_reg[AW-1:0]] <= wrec.status;
                    if (wrec.status != ST_OK)
                    begin
                        ok_acc_reg <= 1'b0;
                    end
                    if (idx_reg == LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_LAMPS;
                        if (do_check_reg)
                        begin
                            last_chk_reg <= time_reg;
                            healthy_reg  <= ok_acc_reg && (wrec.status == ST_OK);
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TICK_RD;
                    end
                end
                S_LAMPS:
                begin
                    mode_reg[0] <= healthy_reg ? MODE_ON : MODE_SLOW;
                    mode_reg[1] <= healthy_reg ? MODE_OFF : MODE_FAST;
                    for (int k = 0; k < SYSTEMS; k++)
                    begin
                        mode_reg[k+2] <= mode_for_status(sys_st_reg[k]);
                    end
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    for (int k = 0; k < LAMPS; k++)
                    begin
                        unique case (mode_reg[k])
                            MODE_OFF: lvl_reg[k] <= 1'b0;
                            MODE_ON:  lvl_reg[k] <= 1'b1;
                            default:
                            begin
                                if ((time_reg - tog_reg[k]) >= {16'd0,
                                    (mode_reg[k] == MODE_SLOW) ? blink_reg
                                                               : {1'b0, blink_reg[15:1]}})
                                begin
                                    lvl_reg[k] <= !lvl_reg[k];
                                    tog_reg[k] <= time_reg;
                                end
                            end
                        endcase
                    end
                    if (test_act_reg && ((time_reg - last_test_reg) >= 32'(TEST_PHASE_MS)))
                    begin
                        last_test_reg <= time_reg;
                        if (phase_reg + 5'd1 >= PHASE_END)
                        begin
                            test_act_reg <= 1'b0;
                            phase_reg    <= '0;
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 5'd1;
                        end
                    end
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (!(out_valid && out_stall))
                    begin
                        out_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result capture: updated record is held in S_MOD/S_TICK_MOD; outputs latch in S_HOLD from that copy
    logic        rc_reg;
    logic [2:0]  st_o_reg;
    logic [15:0] fc_o_reg;
    logic [31:0] cnt_o_reg;
    logic [7:0]  lamps_o;
    sys_rec_t    rec_hold_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MOD || state_reg == S_TICK_MOD)
        begin
            if (state_reg == S_MOD || idx_reg[AW-1:0] == id_reg[AW-1:0])
            begin
                rec_hold_reg <= wrec;
            end
        end
        if (state_reg == S_HOLD && !(out_valid && out_stall))
        begin
            rc_reg    <= (op_reg == OP_HEARTBEAT || op_reg == OP_REPORT ||
                          op_reg == OP_CLEAR || op_reg == OP_READ) && !valid_id;
            st_o_reg  <= valid_id ? rec_hold_reg.status : '0;
            fc_o_reg  <= valid_id ? rec_hold_reg.fault : '0;
            cnt_o_reg <= valid_id ? rec_hold_reg.tally : '0;
        end
    end

    always_comb
    begin
        lamps_o = '0;
        for (int k = 0; k < SHOWN; k++)
        begin
            lamps_o[k] = lvl_reg[k+2];
        end
    end

    assign result_code        = rc_reg;
    assign system_status      = st_o_reg;
    assign system_fault_code  = fc_o_reg;
    assign system_fault_count = cnt_o_reg;
    assign all_ok             = healthy_reg;
    assign total_fault_count  = sum_reg;
    assign uptime_ms          = time_reg;
    assign status_lamp        = lvl_reg[0];
    assign fault_lamp         = lvl_reg[1];
    assign system_lamps       = lamps_o;
    assign test_running       = test_act_reg;
    assign test_step          = phase_reg[3:0];
endmodule

FILE: dv/tb.sv
// Self-checking testbench for the subsystem heartbeat health monitor.
`timescale 1ns / 1ps

module tb;
    import shhm_pkg::*;

    localparam int NSYS = 8;
    localparam int NLAMP = NSYS + 2;
    localparam int PHASE_MS = 1000;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  id;
        logic [15:0] code;
    } cmd_t;

    typedef struct packed {
        logic        rc;
        logic [2:0]  st;
        logic [15:0] fc;
        logic [31:0] cnt;
        logic        aok;
        logic [31:0] tot;
        logic [31:0] up;
        logic        slamp;
        logic        flamp;
        logic [7:0]  lamps;
        logic        trun;
        logic [3:0]  tstep;
    } status_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] operation = '0;
    logic [3:0] sys_sel = '0;
    logic [15:0] fault_val = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic result_code;
    logic [2:0] system_status;
    logic [15:0] system_fault_code;
    logic [31:0] system_fault_count;
    logic all_ok;
    logic [31:0] total_fault_count;
    logic [31:0] uptime_ms;
    logic status_lamp;
    logic fault_lamp;
    logic [7:0] system_lamps;
    logic test_running;
    logic [3:0] test_step;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    subsystem_heartbeat_health_monitor_top u_dut (.*);

    always #1 clk = ~clk;

    // predictor state
    logic [15:0] m_check, m_timeout, m_blink;
    logic        m_test_start;
    logic [31:0] m_now, m_last_check, m_last_test, m_sum;
    logic [2:0]  m_status [NSYS];
    logic [15:0] m_fault [NSYS];
    logic [31:0] m_tally [NSYS];
    logic [31:0] m_beat [NSYS];
    logic [1:0]  m_mode [NLAMP];
    logic [31:0] m_toggle [NLAMP];
    logic        m_level [NLAMP];
    logic        m_healthy, m_test_on;
    logic [31:0] m_phase;

    cmd_t         pending_cmds[$];
    status_word_t expected_words[$];
    int  errors = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  stim_done = 0;

    task automatic model_reset();
        m_check = 16'd1000; m_timeout = 16'd2000; m_blink = 16'd500; m_test_start = 1'b1;
        m_now = '0; m_last_check = '0; m_last_test = '0; m_sum = '0;
        m_healthy = 1'b0; m_test_on = 1'b0; m_phase = '0;
        for (int i = 0; i < NSYS; i++)
        begin
            m_status[i] = ST_UNKNOWN; m_fault[i] = '0; m_tally[i] = '0; m_beat[i] = '0;
        end
        for (int i = 0; i < NLAMP; i++)
        begin
            m_mode[i] = MODE_OFF; m_toggle[i] = '0; m_level[i] = 1'b0;
        end
    endtask

    function automatic logic [1:0] lamp_mode_of(logic [2:0] st);
        case (st)
            ST_OK:      return MODE_ON;
            ST_WARNING: return MODE_SLOW;
            ST_ERROR:   return MODE_FAST;
            ST_OFFLINE: return MODE_OFF;
            default:    return MODE_SLOW;
        endcase
    endfunction

    task automatic monitor_tick();
        logic ok;
        logic [31:0] per;
        m_now++;
        if (m_now - m_last_check >= {16'd0, m_check})
        begin
            m_last_check = m_now;
            ok = 1'b1;
            for (int i = 0; i < NSYS; i++)
            begin
                if (m_now - m_beat[i] > {16'd0, m_timeout})
                begin
                    m_status[i] = ST_OFFLINE; m_fault[i] = '0; m_beat[i] = m_now;
                end
                if (m_status[i] != ST_OK)
                    ok = 1'b0;
            end
            m_healthy = ok;
        end
        m_mode[0] = m_healthy ? MODE_ON : MODE_SLOW;
        m_mode[1] = m_healthy ? MODE_OFF : MODE_FAST;
        for (int i = 0; i < NSYS; i++)
            m_mode[i + 2] = lamp_mode_of(m_status[i]);
        for (int k = 0; k < NLAMP; k++)
        begin
            if (m_mode[k] == MODE_OFF)
                m_level[k] = 1'b0;
            else if (m_mode[k] == MODE_ON)
                m_level[k] = 1'b1;
            else
            begin
                per = (m_mode[k] == MODE_SLOW) ? {16'd0, m_blink} : {17'd0, m_blink[15:1]};
                if (m_now - m_toggle[k] >= per)
                begin
                    m_level[k] = ~m_level[k]; m_toggle[k] = m_now;
                end
            end
        end
        if (m_test_on && (m_now - m_last_test >= 32'(PHASE_MS)))
        begin
            m_last_test = m_now;
            m_phase++;
            if (m_phase >= 32'(NSYS + 3))
            begin
                m_test_on = 1'b0; m_phase = '0;
            end
        end
    endtask

    task automatic predict_status(cmd_t c);
        status_word_t w;
        logic v;
        v = c.id < NSYS;
        w.rc = 1'b0;
        case (op_t'(c.op))
            OP_TICK: monitor_tick();
            OP_HEARTBEAT:
                if (!v) w.rc = 1'b1;
                else
                begin
                    m_beat[c.id] = m_now;
                    if (m_status[c.id] == ST_OFFLINE) m_status[c.id] = ST_OK;
                end
            OP_REPORT:
                if (!v) w.rc = 1'b1;
                else
                begin
                    m_status[c.id] = ST_ERROR; m_fault[c.id] = c.code;
                    m_beat[c.id] = m_now; m_tally[c.id]++; m_sum++;
                end
            OP_CLEAR:
                if (!v) w.rc = 1'b1;
                else
                begin
                    m_status[c.id] = ST_OK; m_fault[c.id] = '0; m_beat[c.id] = m_now;
                end
            OP_START:
                if (m_test_start)
                begin
                    m_test_on = 1'b1; m_phase = '0;
                end
            OP_STOP: m_test_on = 1'b0;
            OP_TEST:
            begin
                m_test_on = 1'b1; m_phase = '0;
            end
            default: if (!v) w.rc = 1'b1;
        endcase
        w.st = v ? m_status[c.id] : 3'd0;
        w.fc = v ? m_fault[c.id] : 16'd0;
        w.cnt = v ? m_tally[c.id] : 32'd0;
        w.aok = m_healthy;
        w.tot = m_sum;
        w.up = m_now;
        w.slamp = m_level[0];
        w.flamp = m_level[1];
        for (int i = 0; i < NSYS; i++)
            w.lamps[i] = m_level[i + 2];
        w.trun = m_test_on;
        w.tstep = m_phase[3:0];
        expected_words.push_back(w);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    predict_status(c);
                    in_valid <= 1'b1;
                    operation <= c.op;
                    sys_sel <= c.id;
                    fault_val <= c.code;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("unexpected word at %0t", $realtime);
            end
            else
            begin
                status_word_t e;
                e = expected_words.pop_front();
                if (result_code !== e.rc)
                    report_mismatch("result_code", 32'(result_code), 32'(e.rc));
                if (system_status !== e.st)
                    report_mismatch("system_status", 32'(system_status), 32'(e.st));
                if (system_fault_code !== e.fc)
                    report_mismatch("system_fault_code", 32'(system_fault_code), 32'(e.fc));
                if (system_fault_count !== e.cnt)
                    report_mismatch("system_fault_count", system_fault_count, e.cnt);
                if (all_ok !== e.aok) report_mismatch("all_ok", 32'(all_ok), 32'(e.aok));
                if (total_fault_count !== e.tot)
                    report_mismatch("total_fault_count", total_fault_count, e.tot);
                if (uptime_ms !== e.up) report_mismatch("uptime_ms", uptime_ms, e.up);
                if (status_lamp !== e.slamp)
                    report_mismatch("status_lamp", 32'(status_lamp), 32'(e.slamp));
                if (fault_lamp !== e.flamp)
                    report_mismatch("fault_lamp", 32'(fault_lamp), 32'(e.flamp));
                if (system_lamps !== e.lamps)
                    report_mismatch("system_lamps", 32'(system_lamps), 32'(e.lamps));
                if (test_running !== e.trun)
                    report_mismatch("test_running", 32'(test_running), 32'(e.trun));
                if (test_step !== e.tstep)
                    report_mismatch("test_step", 32'(test_step), 32'(e.tstep));
            end
        end
    end

    task automatic add_cmd(op_t op, int id, int code);
        cmd_t c;
        c.op = op; c.id = id[3:0]; c.code = code[15:0];
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CHECK:   m_check = val;
            REG_TIMEOUT: m_timeout = val;
            REG_BLINK:   m_blink = val;
            default:     m_test_start = val[0];
        endcase
        @(posedge clk);
    endtask

    // mostly ticks with health traffic, some noise
    task automatic random_burst(int n);
        for (int i = 0; i < n; i++)
        begin
            int r;
            int id;
            r = $urandom_range(99);
            id = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(NSYS - 1);
            if (r < 55) add_cmd(OP_TICK, $urandom_range(15), $urandom);
            else if (r < 70) add_cmd(OP_HEARTBEAT, id, $urandom);
            else if (r < 78) add_cmd(OP_REPORT, id, $urandom);
            else if (r < 85) add_cmd(OP_CLEAR, id, $urandom);
            else if (r < 88) add_cmd(OP_START, id, $urandom);
            else if (r < 90) add_cmd(OP_STOP, id, $urandom);
            else if (r < 92) add_cmd(OP_TEST, id, $urandom);
            else add_cmd(OP_READ, id, $urandom);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (NSYS + 4) @(posedge clk);

        write_reg(REG_CHECK, 3);
        write_reg(REG_TIMEOUT, 5);
        write_reg(REG_BLINK, 4);
        write_reg(REG_TEST, 1);
        add_cmd(OP_READ, 0, 0);
        add_cmd(OP_READ, 15, 16'hffff);
        add_cmd(OP_HEARTBEAT, 8, 0);
        add_cmd(OP_REPORT, 7, 16'hffff);
        add_cmd(OP_REPORT, 12, 16'h1234);
        add_cmd(OP_REPORT, 0, 0);
        add_cmd(OP_CLEAR, 9, 0);
        add_cmd(OP_CLEAR, 0, 0);
        add_cmd(OP_HEARTBEAT, 1, 0);
        add_cmd(OP_START, 0, 0);
        for (int i = 0; i < 8; i++) add_cmd(OP_TICK, 0, 0);
        add_cmd(OP_HEARTBEAT, 2, 0);
        add_cmd(OP_STOP, 0, 0);
        add_cmd(OP_TEST, 3, 0);
        add_cmd(OP_TICK, 0, 0);
        drain();

        write_reg(REG_CHECK, 0);
        write_reg(REG_BLINK, 0);
        write_reg(REG_TIMEOUT, 16'hffff);
        write_reg(REG_TEST, 0);
        random_burst(300);
        drain();

        write_reg(REG_CHECK, 1);
        write_reg(REG_TIMEOUT, 1);
        write_reg(REG_BLINK, 2);
        write_reg(REG_TEST, 1);
        send_idle = 78;
        random_burst(300);
        drain();

        write_reg(REG_CHECK, 16'hffff);
        write_reg(REG_TIMEOUT, 3);
        write_reg(REG_BLINK, 16'hffff);
        send_idle = 0; recv_stall = 78;
        random_burst(300);
        drain();

        write_reg(REG_CHECK, 2);
        write_reg(REG_TIMEOUT, 7);
        write_reg(REG_BLINK, 3);
        send_idle = 22; recv_stall = 22;
        random_burst(300);
        drain();

        send_idle = 0; recv_stall = 0;
        random_burst(225);
        drain();
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
